// ----- rtl/sm83alu_pkg.sv -----
package sm83alu_pkg;

   localparam int unsigned FUNC_W  = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned FLAGS_W = 4;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 32;

   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [FUNC_W-1:0] FN_ADD     = 5'd0;
   localparam logic [FUNC_W-1:0] FN_ADC     = 5'd1;
   localparam logic [FUNC_W-1:0] FN_SUB     = 5'd2;
   localparam logic [FUNC_W-1:0] FN_SBC     = 5'd3;
   localparam logic [FUNC_W-1:0] FN_AND     = 5'd4;
   localparam logic [FUNC_W-1:0] FN_XOR     = 5'd5;
   localparam logic [FUNC_W-1:0] FN_OR      = 5'd6;
   localparam logic [FUNC_W-1:0] FN_CP      = 5'd7;
   localparam logic [FUNC_W-1:0] FN_INC     = 5'd8;
   localparam logic [FUNC_W-1:0] FN_DEC     = 5'd9;
   localparam logic [FUNC_W-1:0] FN_RLC     = 5'd10;
   localparam logic [FUNC_W-1:0] FN_RRC     = 5'd11;
   localparam logic [FUNC_W-1:0] FN_RL      = 5'd12;
   localparam logic [FUNC_W-1:0] FN_RR      = 5'd13;
   localparam logic [FUNC_W-1:0] FN_SLA     = 5'd14;
   localparam logic [FUNC_W-1:0] FN_SRA     = 5'd15;
   localparam logic [FUNC_W-1:0] FN_SWAP    = 5'd16;
   localparam logic [FUNC_W-1:0] FN_SRL     = 5'd17;
   localparam logic [FUNC_W-1:0] FN_BIT     = 5'd18;
   localparam logic [FUNC_W-1:0] FN_RES     = 5'd19;
   localparam logic [FUNC_W-1:0] FN_SET     = 5'd20;
   localparam logic [FUNC_W-1:0] FN_DAA     = 5'd21;
   localparam logic [FUNC_W-1:0] FN_CPL     = 5'd22;
   localparam logic [FUNC_W-1:0] FN_SCF     = 5'd23;
   localparam logic [FUNC_W-1:0] FN_CCF     = 5'd24;
   localparam logic [FUNC_W-1:0] FN_RLCA    = 5'd25;
   localparam logic [FUNC_W-1:0] FN_RRCA    = 5'd26;
   localparam logic [FUNC_W-1:0] FN_RLA     = 5'd27;
   localparam logic [FUNC_W-1:0] FN_RRA     = 5'd28;
   localparam logic [FUNC_W-1:0] FN_ADD16   = 5'd29;
   localparam logic [FUNC_W-1:0] FN_ADD_SP  = 5'd30;

   localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;
   localparam logic [BYTE_W-1:0] DAA_HIGH   = 8'h60;
   localparam logic [BYTE_W-1:0] DAA_LOW    = 8'h06;
   localparam logic [3:0]        DIGIT_MAX  = 4'd9;

   typedef struct packed {
      logic [3:0]         pad;
      logic [FLAGS_W-1:0] flags_in;
      logic [WORD_W-1:0]  wide_b;
      logic [WORD_W-1:0]  wide_a;
      logic [INDEX_W-1:0] bit_index;
      logic [BYTE_W-1:0]  operand_b;
      logic [BYTE_W-1:0]  operand_a;
      logic [FUNC_W-1:0]  func;
   } req_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic [FLAGS_W-1:0] flags_out;
      logic [WORD_W-1:0]  wide_result;
      logic [BYTE_W-1:0]  result;
   } rsp_type;

endpackage

// ----- rtl/sm83_alu_with_flags.sv -----
// SM83 arithmetic and logic unit. Each request item carries an operation code, two byte
// operands, a bit index, two 16-bit operands and the incoming Z N H C flags; each response
// item carries the byte result, the 16-bit result and the new flags. An accepted item is held
// in an input register, evaluated by one short pass of adders and selection, and captured in
// an output register, which presents the response. One item is accepted every cycle as long
// as the response side keeps taking items; the output register lets a new item enter while a
// finished one still waits.
module sm83_alu_with_flags (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0 up: func, operand_a, operand_b, bit_index, wide_a, wide_b, flags_in.
   input  logic [sm83alu_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0 up: result, wide_result, flags_out.
   output logic [sm83alu_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sm83alu_pkg::*;

   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    rsp_load;
   logic    req_load;

   logic [BYTE_W-1:0]  a;
   logic [BYTE_W-1:0]  b;
   logic [FLAGS_W-1:0] fi;
   logic               cin;
   logic               cuse;
   logic [BYTE_W:0]    sum9;
   logic [4:0]         sum5;
   logic [BYTE_W:0]    dif9;
   logic [4:0]         dif5;
   logic [WORD_W:0]    sum17;
   logic [12:0]        sum13;
   logic [BYTE_W:0]    sp9;
   logic [4:0]         sp5;
   logic [BYTE_W-1:0]  adj;
   logic               dc;
   logic [BYTE_W-1:0]  r;
   logic [WORD_W-1:0]  w;
   logic [FLAGS_W-1:0] f;
   logic               co;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_load   = !req_valid_ff || rsp_load;
   assign req_tready = req_load;

   assign req_valid_in = req_load ? req_tvalid : req_valid_ff;
   assign req_in       = req_tdata;
   assign rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_tvalid) begin
         req_ff <= req_in;
      end
      if (rsp_load && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign a    = req_ff.operand_a;
   assign b    = req_ff.operand_b;
   assign fi   = req_ff.flags_in;
   assign cin  = fi[FLAG_C];
   assign cuse = (req_ff.func == FN_ADC || req_ff.func == FN_SBC) ? cin : 1'b0;

   assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
   assign sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
   assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
   assign dif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
   assign sum17 = {1'b0, req_ff.wide_a} + {1'b0, req_ff.wide_b};
   assign sum13 = {1'b0, req_ff.wide_a[11:0]} + {1'b0, req_ff.wide_b[11:0]};
   assign sp9   = {1'b0, req_ff.wide_a[7:0]} + {1'b0, b};
   assign sp5   = {1'b0, req_ff.wide_a[3:0]} + {1'b0, b[3:0]};

   always_comb begin
      r   = a;
      w   = '0;
      f   = fi;
      co  = 1'b0;
      adj = '0;
      dc  = cin;
      case (req_ff.func)
         FN_ADD, FN_ADC: begin
            r = sum9[BYTE_W-1:0];
            f = {(r == '0), 1'b0, sum5[4], sum9[BYTE_W]};
         end
         FN_SUB, FN_SBC: begin
            r = dif9[BYTE_W-1:0];
            f = {(r == '0), 1'b1, dif5[4], dif9[BYTE_W]};
         end
         FN_CP: begin
            f = {(dif9[BYTE_W-1:0] == '0), 1'b1, dif5[4], dif9[BYTE_W]};
         end
         FN_AND: begin
            r = a & b;
            f = {(r == '0), 1'b0, 1'b1, 1'b0};
         end
         FN_XOR: begin
            r = a ^ b;
            f = {(r == '0), 3'b000};
         end
         FN_OR: begin
            r = a | b;
            f = {(r == '0), 3'b000};
         end
         FN_INC: begin
            r = a + 8'd1;
            f = {(r == '0), 1'b0, (a[3:0] == 4'hF), fi[FLAG_C]};
         end
         FN_DEC: begin
            r = a - 8'd1;
            f = {(r == '0), 1'b1, (a[3:0] == 4'h0), fi[FLAG_C]};
         end
         FN_RLC, FN_RLCA: begin
            co = a[7];
            r  = {a[6:0], a[7]};
            f  = {(req_ff.func == FN_RLC && r == '0), 2'b00, co};
         end
         FN_RRC, FN_RRCA: begin
            co = a[0];
            r  = {a[0], a[7:1]};
            f  = {(req_ff.func == FN_RRC && r == '0), 2'b00, co};
         end
         FN_RL, FN_RLA: begin
            co = a[7];
            r  = {a[6:0], cin};
            f  = {(req_ff.func == FN_RL && r == '0), 2'b00, co};
         end
         FN_RR, FN_RRA: begin
            co = a[0];
            r  = {cin, a[7:1]};
            f  = {(req_ff.func == FN_RR && r == '0), 2'b00, co};
         end
         FN_SLA: begin
            co = a[7];
            r  = {a[6:0], 1'b0};
            f  = {(r == '0), 2'b00, co};
         end
         FN_SRA: begin
            co = a[0];
            r  = {a[7], a[7:1]};
            f  = {(r == '0), 2'b00, co};
         end
         FN_SWAP: begin
            r = {a[3:0], a[7:4]};
            f = {(r == '0), 3'b000};
         end
         FN_SRL: begin
            co = a[0];
            r  = {1'b0, a[7:1]};
            f  = {(r == '0), 2'b00, co};
         end
         FN_BIT: begin
            f = {!a[req_ff.bit_index], 1'b0, 1'b1, fi[FLAG_C]};
         end
         FN_RES: begin
            r = a & ~(8'd1 << req_ff.bit_index);
         end
         FN_SET: begin
            r = a | (8'd1 << req_ff.bit_index);
         end
         FN_DAA: begin
            if (!fi[FLAG_N]) begin
               if (fi[FLAG_H] || a[3:0] > DIGIT_MAX) begin
                  adj = adj | DAA_LOW;
               end
               if (cin || a > DAA_LIMIT) begin
                  adj = adj | DAA_HIGH;
                  dc  = 1'b1;
               end
               r = a + adj;
            end else begin
               if (fi[FLAG_H]) begin
                  adj = adj | DAA_LOW;
               end
               if (cin) begin
                  adj = adj | DAA_HIGH;
               end
               r = a - adj;
            end
            f = {(r == '0), fi[FLAG_N], 1'b0, dc};
         end
         FN_CPL: begin
            r = ~a;
            f = {fi[FLAG_Z], 1'b1, 1'b1, fi[FLAG_C]};
         end
         FN_SCF: begin
            f = {fi[FLAG_Z], 2'b00, 1'b1};
         end
         FN_CCF: begin
            f = {fi[FLAG_Z], 2'b00, !cin};
         end
         FN_ADD16: begin
            w = sum17[WORD_W-1:0];
            f = {fi[FLAG_Z], 1'b0, sum13[12], sum17[WORD_W]};
         end
         FN_ADD_SP: begin
            w = req_ff.wide_a + {{8{b[7]}}, b};
            f = {2'b00, sp5[4], sp9[BYTE_W]};
         end
         default: begin
            r = a;
         end
      endcase
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.result      = r;
      rsp_in.wide_result = w;
      rsp_in.flags_out   = f;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_load |=> rsp_tvalid)
      else $error("held item did not move to the output register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled while the output register was empty");

   a_wide_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_load && req_ff.func != FN_ADD16 && req_ff.func != FN_ADD_SP
      |=> rsp_ff.wide_result == '0)
      else $error("wide result not zero for a byte operation");

   a_logic_flags: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_load
      && (req_ff.func == FN_AND || req_ff.func == FN_XOR || req_ff.func == FN_OR)
      |=> !rsp_ff.flags_out[FLAG_N] && !rsp_ff.flags_out[FLAG_C])
      else $error("logic operation left N or C set");
`endif

endmodule

// ----- tb/tb_sm83_alu_with_flags.sv -----
`timescale 1ns / 1ps

module tb_sm83_alu_with_flags;
   import sm83alu_pkg::*;

   localparam logic [FUNC_W-1:0] FN_UNUSED = 5'd31;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned RANDOM_BLOCKS = 3;
   localparam int unsigned BLOCK_ITEMS = 150;

   typedef struct {
      req_type     item;
      int unsigned gap;
      bit          drain;
   } stim_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   stim_item_type pending_items[$];
   rsp_type     expected_results[$];
   int unsigned results_owed = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned gap_left = 0;
   int unsigned ready_hold = 0;

   sm83_alu_with_flags dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_type alu_predict(input req_type q);
      logic [BYTE_W-1:0]  a, b, r, adj;
      logic [FLAGS_W-1:0] f;
      logic [WORD_W-1:0]  w;
      logic [8:0]         sum9;
      logic [4:0]         nib;
      logic [12:0]        sum13;
      logic [16:0]        sum17;
      logic               cin, c, co, zf;
      rsp_type            p;
      a = q.operand_a;
      b = q.operand_b;
      f = q.flags_in;
      cin = f[FLAG_C];
      r = a;
      w = '0;
      co = 1'b0;
      case (q.func)
         FN_ADD, FN_ADC, FN_SUB, FN_SBC, FN_CP: begin
            c = (q.func == FN_ADC || q.func == FN_SBC) ? cin : 1'b0;
            if (q.func == FN_ADD || q.func == FN_ADC) begin
               sum9 = {1'b0, a} + {1'b0, b} + {8'd0, c};
               nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
               f[FLAG_H] = nib[4];
               f[FLAG_C] = sum9[8];
               f[FLAG_N] = 1'b0;
            end else begin
               sum9 = {1'b0, a} - {1'b0, b} - {8'd0, c};
               f[FLAG_H] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, c});
               f[FLAG_C] = {1'b0, a} < ({1'b0, b} + {8'd0, c});
               f[FLAG_N] = 1'b1;
            end
            f[FLAG_Z] = (sum9[7:0] == 8'h00);
            if (q.func != FN_CP) r = sum9[7:0];
         end
         FN_AND, FN_XOR, FN_OR: begin
            r = (q.func == FN_AND) ? (a & b) : (q.func == FN_XOR) ? (a ^ b) : (a | b);
            f = '0;
            f[FLAG_Z] = (r == 8'h00);
            f[FLAG_H] = (q.func == FN_AND);
         end
         FN_INC: begin
            r = a + 8'd1;
            f[FLAG_Z] = (r == 8'h00);
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = (a[3:0] == 4'hF);
         end
         FN_DEC: begin
            r = a - 8'd1;
            f[FLAG_Z] = (r == 8'h00);
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = (a[3:0] == 4'h0);
         end
         FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP, FN_SRL,
         FN_RLCA, FN_RRCA, FN_RLA, FN_RRA: begin
            case (q.func)
               FN_RLC, FN_RLCA: begin
                  co = a[7];
                  r = {a[6:0], a[7]};
               end
               FN_RRC, FN_RRCA: begin
                  co = a[0];
                  r = {a[0], a[7:1]};
               end
               FN_RL, FN_RLA: begin
                  co = a[7];
                  r = {a[6:0], cin};
               end
               FN_RR, FN_RRA: begin
                  co = a[0];
                  r = {cin, a[7:1]};
               end
               FN_SLA: begin
                  co = a[7];
                  r = {a[6:0], 1'b0};
               end
               FN_SRA: begin
                  co = a[0];
                  r = {a[7], a[7:1]};
               end
               FN_SWAP: begin
                  co = 1'b0;
                  r = {a[3:0], a[7:4]};
               end
               default: begin
                  co = a[0];
                  r = {1'b0, a[7:1]};
               end
            endcase
            f = '0;
            f[FLAG_Z] = (q.func < FN_RLCA) && (r == 8'h00);
            f[FLAG_C] = co;
         end
         FN_BIT: begin
            f[FLAG_Z] = ~a[q.bit_index];
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = 1'b1;
         end
         FN_RES: r = a & ~(8'h01 << q.bit_index);
         FN_SET: r = a | (8'h01 << q.bit_index);
         FN_DAA: begin
            adj = '0;
            c = cin;
            if (!f[FLAG_N]) begin
               if (f[FLAG_H] || a[3:0] > DIGIT_MAX) adj = adj | DAA_LOW;
               if (c || a > DAA_LIMIT) begin
                  adj = adj | DAA_HIGH;
                  c = 1'b1;
               end
               r = a + adj;
            end else begin
               if (f[FLAG_H]) adj = adj | DAA_LOW;
               if (c) adj = adj | DAA_HIGH;
               r = a - adj;
            end
            f[FLAG_Z] = (r == 8'h00);
            f[FLAG_H] = 1'b0;
            f[FLAG_C] = c;
         end
         FN_CPL: begin
            r = ~a;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = 1'b1;
         end
         FN_SCF, FN_CCF: begin
            zf = f[FLAG_Z];
            f = '0;
            f[FLAG_Z] = zf;
            f[FLAG_C] = (q.func == FN_SCF) ? 1'b1 : ~cin;
         end
         FN_ADD16: begin
            sum17 = {1'b0, q.wide_a} + {1'b0, q.wide_b};
            sum13 = {1'b0, q.wide_a[11:0]} + {1'b0, q.wide_b[11:0]};
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = sum13[12];
            f[FLAG_C] = sum17[16];
            w = sum17[15:0];
         end
         FN_ADD_SP: begin
            nib = {1'b0, q.wide_a[3:0]} + {1'b0, b[3:0]};
            sum9 = {1'b0, q.wide_a[7:0]} + {1'b0, b};
            f = '0;
            f[FLAG_H] = nib[4];
            f[FLAG_C] = sum9[8];
            w = q.wide_a + {{8{b[7]}}, b};
         end
         default: ;
      endcase
      p = '0;
      p.result = r;
      p.wide_result = w;
      p.flags_out = f;
      return p;
   endfunction

   function automatic req_type make_req(input logic [FUNC_W-1:0] fn, input logic [7:0] a,
                                        input logic [7:0] b, input logic [2:0] bi,
                                        input logic [15:0] wa, input logic [15:0] wb,
                                        input logic [3:0] fl);
      req_type q;
      q = '0;
      q.func = fn;
      q.operand_a = a;
      q.operand_b = b;
      q.bit_index = bi;
      q.wide_a = wa;
      q.wide_b = wb;
      q.flags_in = fl;
      return q;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return {4'($urandom), 4'hF};
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {4'($urandom), 12'hFFF};
         3: return {8'($urandom), 4'($urandom), 4'hF};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      else if (roll < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   task automatic queue_op(input req_type item, input int unsigned gap, input bit drain);
      stim_item_type s;
      s.item = item;
      s.gap = gap;
      s.drain = drain;
      pending_items.push_back(s);
   endtask

   always @(posedge clock) begin : drive_req
      stim_item_type next;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      (!pending_items[0].drain || (!req_tvalid && results_owed == 0))) begin
            next = pending_items.pop_front();
            req_tdata <= next.item;
            req_tvalid <= 1'b1;
            gap_left = (pending_items.size() != 0) ? pending_items[0].gap : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_ready
      int unsigned roll;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
         end else if (roll < 92) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type got, want;
      logic took_req, gave_rsp;
      if (reset) begin
         results_owed <= 0;
         idle_cycles = 0;
      end else begin
         took_req = req_tvalid && req_tready;
         gave_rsp = rsp_tvalid && rsp_tready;
         if (took_req) expected_results.push_back(alu_predict(req_type'(req_tdata)));
         if (gave_rsp) begin
            got = rsp_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               $error("response item with no request outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.result !== want.result) begin
                  $error("result: expected %h, actual %h", want.result, got.result);
                  mismatch_count++;
               end
               if (got.wide_result !== want.wide_result) begin
                  $error("wide_result: expected %h, actual %h", want.wide_result,
                         got.wide_result);
                  mismatch_count++;
               end
               if (got.flags_out !== want.flags_out) begin
                  $error("flags_out: expected %h, actual %h", want.flags_out, got.flags_out);
                  mismatch_count++;
               end
            end
         end
         results_owed <= expected_results.size();
         if (took_req || gave_rsp) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sm83_alu_with_flags failed");
            $finish;
         end
      end
   end

   initial begin
      queue_op(make_req(FN_ADD, 8'hFF, 8'h01, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_ADC, 8'h0F, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001), 0, 1'b0);
      queue_op(make_req(FN_SUB, 8'h3C, 8'h3C, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_SUB, 8'h00, 8'h01, 3'd0, 16'h0000, 16'h0000, 4'b1000), 0, 1'b0);
      queue_op(make_req(FN_SBC, 8'h10, 8'h0F, 3'd0, 16'h0000, 16'h0000, 4'b0001), 0, 1'b0);
      queue_op(make_req(FN_CP, 8'h7F, 8'h80, 3'd0, 16'h0000, 16'h0000, 4'b0000), 1, 1'b0);
      queue_op(make_req(FN_AND, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1111), 0, 1'b0);
      queue_op(make_req(FN_XOR, 8'hA5, 8'hA5, 3'd0, 16'h0000, 16'h0000, 4'b0111), 0, 1'b0);
      queue_op(make_req(FN_OR, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0110), 0, 1'b0);
      queue_op(make_req(FN_INC, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0101), 2, 1'b0);
      queue_op(make_req(FN_DEC, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001), 0, 1'b0);
      queue_op(make_req(FN_DEC, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_RLCA, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1111), 0, 1'b0);
      queue_op(make_req(FN_RLC, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_RRA, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1000), 0, 1'b0);
      queue_op(make_req(FN_BIT, 8'h7F, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0101), 0, 1'b0);
      queue_op(make_req(FN_RES, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1010), 0, 1'b0);
      queue_op(make_req(FN_SET, 8'h00, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_DAA, 8'h9A, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_DAA, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0111), 0, 1'b0);
      queue_op(make_req(FN_CPL, 8'h5A, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_SCF, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1110), 0, 1'b0);
      queue_op(make_req(FN_CCF, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0111), 0, 1'b0);
      queue_op(make_req(FN_ADD16, 8'h00, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 4'b1000), 0, 1'b0);
      queue_op(make_req(FN_ADD_SP, 8'h00, 8'hFF, 3'd0, 16'h00FF, 16'h0000, 4'b1111), 0, 1'b0);
      queue_op(make_req(FN_ADD_SP, 8'h00, 8'h80, 3'd0, 16'h0000, 16'h0000, 4'b0000), 0, 1'b0);
      queue_op(make_req(FN_UNUSED, 8'hC3, 8'h3C, 3'd5, 16'hABCD, 16'h1234, 4'b1011), 0, 1'b0);

      // The middle block runs back to back; each block starts only once the ALU has drained.
      for (int unsigned blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         for (int unsigned i = 0; i < BLOCK_ITEMS; i++) begin
            queue_op(make_req(5'($urandom_range(0, 31)), pick_byte(), pick_byte(),
                              3'($urandom_range(0, 7)), pick_word(), pick_word(),
                              4'($urandom_range(0, 15))),
                     (blk == 1) ? 0 : idle_gap(), i == 0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d response items never arrived", expected_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_sm83_alu_with_flags passed");
      end else begin
         $display("tb_sm83_alu_with_flags failed");
      end
      $finish;
   end

endmodule
